>>> sv/sgfs_pkg.sv
package sgfs_pkg;

   localparam int MAX_VARS_DEF    = 128;
   localparam int MAX_CLAUSES_DEF = 512;

   // fixed field widths
   localparam int MODE_W   = 3;
   localparam int IDX_W    = 9;
   localparam int VAR_W    = 7;
   localparam int NVARS_W  = 8;
   localparam int CFG_W    = 10;
   localparam int OUTCNT_W = 10;
   localparam int SWEEP_W  = 16;
   localparam int LIT_W    = 8;
   localparam int CLAUSE_W = 3 * LIT_W;
   localparam int CSR_IDX_W = 2;

   // widths for the largest supported store, used on internal buses
   localparam int BUS_CNT_W  = 17;
   localparam int BUS_ADDR_W = 16;
   localparam int BUS_VAR_W  = 13;

   localparam logic [OUTCNT_W-1:0] OUTCNT_MAX = '1;

   typedef enum logic [MODE_W-1:0] {
      MODE_WR_CLAUSE = 3'd0,
      MODE_WR_BIT    = 3'd1,
      MODE_SWEEP     = 3'd2,
      MODE_SOLVE     = 3'd3,
      MODE_COUNT     = 3'd4,
      MODE_RD_BIT    = 3'd5,
      MODE_RSVD6     = 3'd6,
      MODE_RSVD7     = 3'd7
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_VARS    = 2'd0,
      CSR_NUM_CLAUSES = 2'd1,
      CSR_TOLERANCE   = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic                  start;
      logic                  flip_en;
      logic [BUS_VAR_W-1:0]  flip_var;
      logic [BUS_CNT_W-1:0]  num_clauses;
      logic [BUS_VAR_W-1:0]  num_vars;
      logic                  wr_en;
      logic [BUS_ADDR_W-1:0] wr_addr;
      logic [CLAUSE_W-1:0]   wr_data;
   } cnt_ctrl_type;

   typedef struct packed {
      logic                 done;
      logic [BUS_CNT_W-1:0] count;
   } cnt_stat_type;

endpackage

>>> sv/sgfs_if.sv
interface sgfs_req_if import sgfs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [IDX_W-1:0]   index;
   logic [VAR_W-1:0]   first_var;
   logic               first_neg;
   logic [VAR_W-1:0]   second_var;
   logic               second_neg;
   logic [VAR_W-1:0]   third_var;
   logic               third_neg;
   logic               bit_in;
   logic [SWEEP_W-1:0] max_sweeps;

   modport source (output valid, mode, index, first_var, first_neg, second_var, second_neg,
                   third_var, third_neg, bit_in, max_sweeps, input ready);
   modport sink (input valid, mode, index, first_var, first_neg, second_var, second_neg,
                 third_var, third_neg, bit_in, max_sweeps, output ready);
endinterface

interface sgfs_rsp_if import sgfs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OUTCNT_W-1:0] unsat_count;
   logic                solved;
   logic                bit_out;
   logic                status;

   modport source (output valid, unsat_count, solved, bit_out, status, input ready);
   modport sink (input valid, unsat_count, solved, bit_out, status, output ready);
endinterface

>>> sv/sgfs_counter.sv
// Unsat counter: one clause read per cycle from the clause memory,
// optional single-variable flip applied on the fly.
module sgfs_counter import sgfs_pkg::*; #(
   parameter int MAX_VARS    = MAX_VARS_DEF,
   parameter int MAX_CLAUSES = MAX_CLAUSES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cnt_ctrl_type        ctrl,
   input  logic [MAX_VARS-1:0] assign_bits,
   output cnt_stat_type        stat
);
   localparam int NCW = $clog2(MAX_CLAUSES + 1);
   localparam int CAW = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;
   localparam int VW  = $clog2(MAX_VARS);

   logic [CLAUSE_W-1:0] mem [MAX_CLAUSES];
   logic [CLAUSE_W-1:0] rd_ff;
   logic                run_ff, run_in;
   logic                pend_ff, pend_in;
   logic                done_ff, done_in;
   logic [NCW-1:0]      addr_ff, addr_in;
   logic [NCW-1:0]      cnt_ff, cnt_in;
   logic [NCW-1:0]      nc;
   logic                issue;
   logic                sat;

   function automatic logic lit_val(input logic [LIT_W-1:0] lit,
                                    input logic [MAX_VARS-1:0] bits,
                                    input logic [BUS_VAR_W-1:0] nv,
                                    input logic fen,
                                    input logic [BUS_VAR_W-1:0] fvar);
      logic [BUS_VAR_W-1:0] v;
      logic                 val;
      v   = BUS_VAR_W'(lit[VAR_W-1:0]);
      val = 1'b0;
      if (v < nv) begin
         val = bits[VW'(v)];
      end
      if (fen && (v == fvar)) begin
         val = ~val;
      end
      return val ^ lit[LIT_W-1];
   endfunction

   assign nc    = NCW'(ctrl.num_clauses);
   assign issue = run_ff && (addr_ff < nc);
   assign sat   = lit_val(rd_ff[LIT_W-1:0], assign_bits, ctrl.num_vars, ctrl.flip_en,
                          ctrl.flip_var)
               || lit_val(rd_ff[2*LIT_W-1:LIT_W], assign_bits, ctrl.num_vars, ctrl.flip_en,
                          ctrl.flip_var)
               || lit_val(rd_ff[3*LIT_W-1:2*LIT_W], assign_bits, ctrl.num_vars,
                          ctrl.flip_en, ctrl.flip_var);

   always_comb begin
      run_in  = run_ff;
      addr_in = addr_ff;
      cnt_in  = cnt_ff;
      pend_in = issue;
      done_in = 1'b0;
      if (ctrl.start) begin
         run_in  = 1'b1;
         addr_in = '0;
         cnt_in  = '0;
         pend_in = 1'b0;
      end else begin
         if (issue) begin
            addr_in = NCW'(addr_ff + 1'b1);
         end
         if (pend_ff && !sat) begin
            cnt_in = NCW'(cnt_ff + 1'b1);
         end
         if (run_ff && !issue && !pend_ff) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         pend_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         pend_ff <= pend_in;
         done_ff <= done_in;
      end
      addr_ff <= addr_in;
      cnt_ff  <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[CAW'(ctrl.wr_addr)] <= ctrl.wr_data;
      end
      rd_ff <= mem[addr_ff[CAW-1:0]];
   end

   assign stat.done  = done_ff;
   assign stat.count = BUS_CNT_W'(cnt_ff);

endmodule

>>> sv/sat_greedy_flip_sweep.sv
// Greedy 3-SAT local search engine.
// req_if carries one command beat (mode plus operands); rsp_if returns exactly
// one result beat per command. csr_we/csr_index/csr_wdata set num_vars,
// num_clauses and tolerance; write them only while the block is idle.
// Every command begins with a pass over the num_clauses clauses in use, one
// clause read per cycle, from the start strobe through the registered read
// to the done flag.
// Write/count/read commands take one pass. A sweep command takes one pass
// plus one sweep; solve takes one pass plus up to max_sweeps sweeps. A sweep
// is num_vars passes, one per tried variable, then the ST_SWEND step. The
// clause memory read port is the bottleneck.
// req_if.ready is high only while idle: one command in flight at a time.
// The result is held in rsp_if until taken; a stalled receiver simply keeps
// the block busy, nothing is dropped.
// Reset clears the assignment to all zero, num_vars to 128, num_clauses and
// tolerance to 0. The clause memory is not cleared; clauses must be written
// before they are counted.
module sat_greedy_flip_sweep import sgfs_pkg::*; #(
   parameter int MAX_VARS    = MAX_VARS_DEF,
   parameter int MAX_CLAUSES = MAX_CLAUSES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   sgfs_req_if.sink             req_if,
   sgfs_rsp_if.source           rsp_if,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);
   localparam int VW  = $clog2(MAX_VARS);
   localparam int NVW = $clog2(MAX_VARS + 1);
   localparam int NCW = $clog2(MAX_CLAUSES + 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_COUNT = 5'b00010,
      ST_TRY   = 5'b00100,
      ST_SWEND = 5'b01000,
      ST_RESP  = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [NVARS_W-1:0]   nvars_ff;
   logic [CFG_W-1:0]     nclauses_ff;
   logic [CFG_W-1:0]     tol_ff;
   logic [MAX_VARS-1:0]  assign_ff, assign_in;
   mode_type             mode_ff, mode_in;
   logic [SWEEP_W-1:0]   limit_ff, limit_in;
   logic [SWEEP_W-1:0]   sweeps_ff, sweeps_in;
   logic [NVW-1:0]       var_ff, var_in;
   logic [NCW-1:0]       best_ff, best_in;
   logic                 changed_ff, changed_in;
   logic                 start_ff, start_in;
   logic                 solved_ff, solved_in;
   logic                 bit_ff, bit_in_r;
   logic                 status_ff, status_in;
   logic [NVW-1:0]       nv_eff;
   logic [NCW-1:0]       nc_eff;
   logic [NCW-1:0]       now;
   logic                 accept;
   cnt_ctrl_type         cctrl;
   cnt_stat_type         cstat;

   // effective sizes, clamped to the store depths
   assign nv_eff = (32'(nvars_ff) > MAX_VARS) ? NVW'(MAX_VARS) : NVW'(nvars_ff);
   assign nc_eff = (32'(nclauses_ff) > MAX_CLAUSES) ? NCW'(MAX_CLAUSES) : NCW'(nclauses_ff);
   assign now    = NCW'(cstat.count);

   assign accept = (state_ff == ST_IDLE) && req_if.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         nvars_ff    <= NVARS_W'(128);
         nclauses_ff <= '0;
         tol_ff      <= '0;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_NUM_VARS:    nvars_ff    <= csr_wdata[NVARS_W-1:0];
            CSR_NUM_CLAUSES: nclauses_ff <= csr_wdata;
            CSR_TOLERANCE:   tol_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in   = state_ff;
      assign_in  = assign_ff;
      mode_in    = mode_ff;
      limit_in   = limit_ff;
      sweeps_in  = sweeps_ff;
      var_in     = var_ff;
      best_in    = best_ff;
      changed_in = changed_ff;
      start_in   = 1'b0;
      solved_in  = solved_ff;
      bit_in_r   = bit_ff;
      status_in  = status_ff;

      cctrl.wr_en   = 1'b0;
      cctrl.wr_addr = BUS_ADDR_W'(req_if.index);
      cctrl.wr_data = {req_if.third_neg, req_if.third_var, req_if.second_neg,
                       req_if.second_var, req_if.first_neg, req_if.first_var};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               mode_in   = mode_type'(req_if.mode);
               limit_in  = req_if.max_sweeps;
               solved_in = 1'b0;
               bit_in_r  = 1'b0;
               status_in = 1'b0;
               case (mode_type'(req_if.mode))
                  MODE_WR_CLAUSE: begin
                     if (32'(req_if.index) < MAX_CLAUSES) begin
                        cctrl.wr_en = 1'b1;
                     end else begin
                        status_in = 1'b1;
                     end
                  end
                  MODE_WR_BIT: begin
                     if (32'(req_if.index) < 32'(nv_eff)) begin
                        assign_in[VW'(req_if.index)] = req_if.bit_in;
                     end else begin
                        status_in = 1'b1;
                     end
                  end
                  MODE_RD_BIT: begin
                     if (32'(req_if.index) < 32'(nv_eff)) begin
                        bit_in_r = assign_ff[VW'(req_if.index)];
                     end else begin
                        status_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
               start_in = 1'b1;
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (cstat.done) begin
               best_in    = now;
               var_in     = '0;
               changed_in = 1'b0;
               sweeps_in  = '0;
               if ((mode_ff == MODE_SWEEP)
                   || ((mode_ff == MODE_SOLVE) && (limit_ff != '0))) begin
                  if (nv_eff == '0) begin
                     state_in = ST_SWEND;
                  end else begin
                     start_in = 1'b1;
                     state_in = ST_TRY;
                  end
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_TRY: begin
            if (cstat.done) begin
               // keep the flip only on a strict improvement
               if (now < best_ff) begin
                  best_in    = now;
                  changed_in = 1'b1;
                  assign_in[var_ff[VW-1:0]] = ~assign_ff[var_ff[VW-1:0]];
               end
               var_in = NVW'(var_ff + 1'b1);
               if (NVW'(var_ff + 1'b1) == nv_eff) begin
                  state_in = ST_SWEND;
               end else begin
                  start_in = 1'b1;
               end
            end
         end
         ST_SWEND: begin
            sweeps_in  = SWEEP_W'(sweeps_ff + 1'b1);
            var_in     = '0;
            changed_in = 1'b0;
            if (mode_ff != MODE_SOLVE) begin
               state_in = ST_RESP;
            end else if (32'(best_ff) <= 32'(tol_ff)) begin
               solved_in = 1'b1;
               state_in  = ST_RESP;
            end else if (!changed_ff || (SWEEP_W'(sweeps_ff + 1'b1) == limit_ff)) begin
               state_in = ST_RESP;
            end else if (nv_eff == '0) begin
               state_in = ST_SWEND;
            end else begin
               start_in = 1'b1;
               state_in = ST_TRY;
            end
         end
         ST_RESP: begin
            if (rsp_if.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      cctrl.start       = start_ff;
      cctrl.flip_en     = (state_ff == ST_TRY);
      cctrl.flip_var    = BUS_VAR_W'(var_ff);
      cctrl.num_clauses = BUS_CNT_W'(nc_eff);
      cctrl.num_vars    = BUS_VAR_W'(nv_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         assign_ff <= '0;
         start_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         assign_ff <= assign_in;
         start_ff  <= start_in;
      end
      mode_ff    <= mode_in;
      limit_ff   <= limit_in;
      sweeps_ff  <= sweeps_in;
      var_ff     <= var_in;
      best_ff    <= best_in;
      changed_ff <= changed_in;
      solved_ff  <= solved_in;
      bit_ff     <= bit_in_r;
      status_ff  <= status_in;
   end

   sgfs_counter #(
      .MAX_VARS    (MAX_VARS),
      .MAX_CLAUSES (MAX_CLAUSES)
   ) u_counter (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (cctrl),
      .assign_bits (assign_ff),
      .stat        (cstat)
   );

   assign req_if.ready       = (state_ff == ST_IDLE);
   assign rsp_if.valid       = (state_ff == ST_RESP);
   assign rsp_if.unsat_count = (32'(best_ff) > 32'(OUTCNT_MAX)) ? OUTCNT_MAX
                                                                : OUTCNT_W'(best_ff);
   assign rsp_if.solved      = solved_ff;
   assign rsp_if.bit_out     = bit_ff;
   assign rsp_if.status      = status_ff;

endmodule

>>> sv/sgfs_checker.sv
module sgfs_checker import sgfs_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [OUTCNT_W-1:0] rsp_unsat_count,
   input logic                rsp_solved,
   input logic                rsp_bit_out,
   input logic                rsp_status
);
   // one command in flight: no new beat while a result waits
   a_busy_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("req ready while result pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (!req_ready && !rsp_valid))
      else $error("block not busy after accept");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_unsat_count)
                                      && $stable(rsp_solved)))
      else $error("stalled result changed");

   a_solved_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_solved) |-> (!rsp_status && !rsp_bit_out))
      else $error("solved with status or bit set");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind sat_greedy_flip_sweep sgfs_checker u_sgfs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_unsat_count (rsp_if.unsat_count),
   .rsp_solved      (rsp_if.solved),
   .rsp_bit_out     (rsp_if.bit_out),
   .rsp_status      (rsp_if.status)
);
